>>> rtl/core/chained_hash_map_unit_assert.svh
// Assertion macros for the chained hash map unit.
`ifndef CHAINED_HASH_MAP_UNIT_ASSERT_SVH
`define CHAINED_HASH_MAP_UNIT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define CHM_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CHM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/chm_pkg.sv
// Package: sizes, codes and entry layout of the chained hash map.
`default_nettype none
package chm_pkg;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_WIDTH = 32;
    localparam int BUCKETS     = 256;   // power of two: bucket is the low hash bits
    localparam int ENTRIES     = 1024;

    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 11;
    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int ADDR_W  = $clog2(ENTRIES);
    localparam int IDX_W   = $clog2(ENTRIES + 1);

    localparam logic [IDX_W-1:0] NIL = IDX_W'(ENTRIES);
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BYTES >= 8) ? {KEY_W{1'b1}} : ((KEY_W'(1) << (8 * KEY_BYTES)) - KEY_W'(1));

    localparam logic [63:0] DJB2_SEED = 64'd5381;
    localparam int          DJB2_SHIFT = 5;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_MEMORY = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic [VALUE_WIDTH-1:0] value;
        logic [IDX_W-1:0]       link;
    } t_entry;
endpackage
`default_nettype wire

>>> rtl/core/chm_if.sv
// Request and response channel interfaces of the chained hash map.
`default_nettype none
interface chm_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [chm_pkg::KEY_W-1:0] key;
    logic [chm_pkg::VAL_W-1:0] value;
    modport source(output valid, req_type, key, value, input ready);
    modport sink(input valid, req_type, key, value, output ready);
endinterface

interface chm_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [chm_pkg::VAL_W-1:0] value_out;
    logic [chm_pkg::CNT_W-1:0] entry_count;
    modport source(output valid, status, value_out, entry_count, input ready);
    modport sink(input valid, status, value_out, entry_count, output ready);
endinterface
`default_nettype wire

>>> rtl/core/chm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module chm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> rtl/core/chm_hash.sv
// Iterative djb2 hash, one key byte per cycle, giving the bucket index.
`default_nettype none
module chm_hash (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [chm_pkg::KEY_W-1:0]   i_key,
    output logic                             o_done,
    output logic      [chm_pkg::BKT_W-1:0]   o_bucket
);
    import chm_pkg::*;

    localparam int BC_W = $clog2(KEY_BYTES + 1);

    logic [63:0]      r_h;
    logic [KEY_W-1:0] r_key;
    logic [BC_W-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_h    <= DJB2_SEED;
                r_key  <= i_key;
            end else if (r_busy) begin
                // h = h*33 + byte
                r_h   <= (r_h << DJB2_SHIFT) + r_h + {56'd0, r_key[7:0]};
                r_key <= r_key >> 8;
                r_cnt <= r_cnt + BC_W'(1);
                if (r_cnt == BC_W'(KEY_BYTES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_h[BKT_W-1:0];
endmodule
`default_nettype wire

>>> rtl/core/chained_hash_map_unit.sv
// Top level: chained hash map, request sequencer around bucket and entry RAMs.
// Sequence: hash the 8 key bytes and read the bucket head, latch it, then walk the chain
//   in S_WALK and S_ENT per node visited, end the walk, apply, and load the response word;
//   a remove that hits adds S_REM2, and reuse of a freed slot adds S_ALLOC, before the load.
// Requests: one at a time; the next word is taken the cycle after the response loads,
//   and the load itself waits while the previous response is not yet taken.
`default_nettype none
`include "chained_hash_map_unit_assert.svh"
module chained_hash_map_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    chm_req_if.sink    i_req,
    chm_rsp_if.source  o_rsp
);
    import chm_pkg::*;

    // Reset: bucket heads are cleared at once by per-bucket valid flags; the free
    // pool uses a fill mark, so no clearing pass is needed after reset.

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_HEAD, S_WALK, S_ENT, S_ACT, S_ALLOC, S_REM2, S_DONE
    } t_state;

    t_state            r_state;
    logic [1:0]        r_req;
    logic [KEY_W-1:0]  r_key;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [BKT_W-1:0]  r_bkt;
    logic [IDX_W-1:0]  r_e, r_prev, r_head, r_steps;
    t_entry            r_word, r_prev_word;
    logic              r_found;
    logic [IDX_W-1:0]  r_free;     // head of free pool
    logic [IDX_W-1:0]  r_fresh;    // slots at or above this were never used
    logic [CNT_W-1:0]  r_count;
    logic [1:0]        r_st;
    logic [VAL_W-1:0]  r_vo;
    logic              r_ovalid;
    logic [1:0]        r_ostatus;
    logic [VAL_W-1:0]  r_ovalue;
    logic [CNT_W-1:0]  r_ocount;

    logic              r_head_vld [BUCKETS];
    logic              r_hd_rvld;

    logic              accept;
    logic              hash_done;
    logic [BKT_W-1:0]  hash_bkt;

    logic              ent_we, ent_re;
    logic [ADDR_W-1:0] ent_waddr, ent_raddr;
    t_entry            ent_wdata, ent_rdata;
    logic              hd_we, hd_re;
    logic [BKT_W-1:0]  hd_waddr, hd_raddr;
    logic [IDX_W-1:0]  hd_wdata, hd_rdata;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    chm_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_key    (i_req.key & KEY_MASK),
        .o_done   (hash_done),
        .o_bucket (hash_bkt)
    );

    chm_ram #(.DEPTH(ENTRIES), .WIDTH($bits(t_entry))) u_entries (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    chm_ram #(.DEPTH(BUCKETS), .WIDTH(IDX_W)) u_heads (
        .i_clk   (i_clk),
        .i_we    (hd_we),
        .i_waddr (hd_waddr),
        .i_wdata (hd_wdata),
        .i_re    (hd_re),
        .i_raddr (hd_raddr),
        .o_rdata (hd_rdata)
    );

    // Memory access decode per state.
    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = r_e[ADDR_W-1:0];
        ent_wdata = r_word;
        ent_re    = 1'b0;
        ent_raddr = r_e[ADDR_W-1:0];
        hd_we     = 1'b0;
        hd_waddr  = r_bkt;
        hd_wdata  = r_free;
        hd_re     = 1'b0;
        hd_raddr  = hash_bkt;
        case (r_state)
            S_HASH: begin
                hd_re = hash_done;
            end
            S_WALK: begin
                ent_re = (r_e != NIL) && (r_steps != IDX_W'(ENTRIES));
            end
            S_ACT: begin
                case (r_req)
                    REQ_INSERT: begin
                        if (r_found) begin
                            // overwrite value in place
                            ent_we          = 1'b1;
                            ent_wdata.value = r_val;
                        end else if (r_free != NIL) begin
                            if (r_free < r_fresh) begin
                                ent_re    = 1'b1;
                                ent_raddr = r_free[ADDR_W-1:0];
                            end else begin
                                // untouched slot: its successor is the next index
                                ent_we    = 1'b1;
                                ent_waddr = r_free[ADDR_W-1:0];
                                ent_wdata = '{key: r_key, value: r_val, link: r_head};
                                hd_we     = 1'b1;
                            end
                        end
                    end
                    REQ_REMOVE: begin
                        if (r_found) begin
                            if (r_prev == NIL) begin
                                hd_we    = 1'b1;
                                hd_wdata = r_word.link;
                            end else begin
                                ent_we         = 1'b1;
                                ent_waddr      = r_prev[ADDR_W-1:0];
                                ent_wdata      = r_prev_word;
                                ent_wdata.link = r_word.link;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_ALLOC: begin
                ent_we    = 1'b1;
                ent_waddr = r_free[ADDR_W-1:0];
                ent_wdata = '{key: r_key, value: r_val, link: r_head};
                hd_we     = 1'b1;
            end
            S_REM2: begin
                ent_we         = 1'b1;
                ent_wdata.link = r_free;
            end
            default: begin
            end
        endcase
    end

    // Bucket valid flags: an unwritten bucket reads as empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUCKETS; i++) begin
                r_head_vld[i] <= 1'b0;
            end
            r_hd_rvld <= 1'b0;
        end else begin
            if (hd_we) begin
                r_head_vld[hd_waddr] <= 1'b1;
            end
            if (hd_re) begin
                r_hd_rvld <= r_head_vld[hd_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_free   <= '0;
            r_fresh  <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (r_ovalid && o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req   <= i_req.req_type;
                        r_key   <= i_req.key & KEY_MASK;
                        r_val   <= i_req.value[VALUE_WIDTH-1:0];
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_bkt   <= hash_bkt;
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_head  <= r_hd_rvld ? hd_rdata : NIL;
                    r_e     <= r_hd_rvld ? hd_rdata : NIL;
                    r_prev  <= NIL;
                    r_steps <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if ((r_e == NIL) || (r_steps == IDX_W'(ENTRIES))) begin
                        r_found <= 1'b0;
                        r_state <= S_ACT;
                    end else begin
                        r_state <= S_ENT;
                    end
                end
                S_ENT: begin
                    if (ent_rdata.key == r_key) begin
                        r_found <= 1'b1;
                        r_word  <= ent_rdata;
                        r_state <= S_ACT;
                    end else begin
                        r_prev      <= r_e;
                        r_prev_word <= ent_rdata;
                        r_e         <= ent_rdata.link;
                        r_steps     <= r_steps + IDX_W'(1);
                        r_state     <= S_WALK;
                    end
                end
                S_ACT: begin
                    r_vo    <= '0;
                    r_st    <= ST_NOT_FOUND;
                    r_state <= S_DONE;
                    case (r_req)
                        REQ_INSERT: begin
                            if (r_found) begin
                                r_st <= ST_OK;
                            end else if (r_free == NIL) begin
                                r_st <= ST_NO_MEMORY;
                            end else if (r_free < r_fresh) begin
                                r_state <= S_ALLOC;
                            end else begin
                                r_st    <= ST_OK;
                                r_free  <= r_free + IDX_W'(1);
                                r_fresh <= r_fresh + IDX_W'(1);
                                r_count <= r_count + CNT_W'(1);
                            end
                        end
                        REQ_LOOKUP: begin
                            if (r_found) begin
                                r_st <= ST_OK;
                                r_vo <= VAL_W'(r_word.value);
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_found) begin
                                r_state <= S_REM2;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_ALLOC: begin
                    r_st    <= ST_OK;
                    r_free  <= ent_rdata.link;
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_DONE;
                end
                S_REM2: begin
                    r_st    <= ST_OK;
                    r_free  <= r_e;
                    if (r_count != '0) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // wait for the response register to free up
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_st;
                        r_ovalue  <= r_vo;
                        r_ocount  <= r_count;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_ostatus;
    assign o_rsp.value_out   = r_ovalue;
    assign o_rsp.entry_count = r_ocount;

    `CHM_ASSERT_HOLDS(a_pool_empty_iff_full,
        (r_free == NIL) == (r_count == CNT_W'(ENTRIES)), "free pool and count disagree")
    `CHM_ASSERT_HOLDS(a_count_within_fill,
        {1'b0, r_count} <= {1'b0, r_fresh}, "entry count above fill mark")
    `CHM_ASSERT_NEXT(a_accept_starts_hash, accept, r_state == S_HASH,
        "accepted word did not start hashing")
    `CHM_ASSERT_NEXT(a_entry_read_used, ent_re,
        (r_state == S_ENT) || (r_state == S_ALLOC), "entry read data not consumed")
endmodule
`default_nettype wire

>>> bench/chained_hash_map_unit_tb.sv
// Testbench for the chained hash map unit: directed and random requests checked per word.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_map_unit_tb;
    import chm_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    chm_req_if req_ch ();
    chm_rsp_if rsp_ch ();

    chained_hash_map_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // One expected response word.
    typedef struct {
        logic [1:0]       status;
        logic [VAL_W-1:0] value_out;
        logic [CNT_W-1:0] entry_count;
    } t_rsp;

    // Shadow of the map: bucket chains over a slot pool, same order as the block.
    int unsigned      map_heads[BUCKETS];
    logic [KEY_W-1:0] map_keys[ENTRIES];
    logic [VAL_W-1:0] map_vals[ENTRIES];
    int unsigned      map_links[ENTRIES];
    int unsigned      map_free;
    int unsigned      map_count;

    t_rsp             rsp_expected[$];
    logic [KEY_W-1:0] known_keys[$];   // keys sent in insert requests at some point, for hits
    int               errors = 0;
    int unsigned      cycle_count = 0;
    bit               rx_hold = 1'b0;   // long receiver hold-off request
    bit               rx_random = 1'b1;

    function automatic int unsigned djb2_bucket(input logic [KEY_W-1:0] k);
        logic [63:0] h;
        h = DJB2_SEED;
        for (int i = 0; i < KEY_BYTES; i++)
            h = (h << DJB2_SHIFT) + h + 64'(k[8*i +: 8]);
        return int'(h % BUCKETS);
    endfunction

    function automatic void map_clear();
        foreach (map_heads[i]) map_heads[i] = ENTRIES;
        foreach (map_links[i]) begin
            map_links[i] = i + 1;
            map_keys[i]  = '0;
            map_vals[i]  = '0;
        end
        map_free  = 0;
        map_count = 0;
    endfunction

    // Apply one request to the shadow map and return the expected response.
    function automatic t_rsp map_apply(input logic [1:0] op, input logic [KEY_W-1:0] k,
                                       input logic [VAL_W-1:0] v);
        t_rsp r;
        int unsigned b, e, prev, steps, n;
        k = k & KEY_MASK;
        b = djb2_bucket(k);
        prev = ENTRIES;
        e = map_heads[b];
        steps = 0;
        r.status = ST_NOT_FOUND;
        r.value_out = '0;
        while (e < ENTRIES && steps < ENTRIES && map_keys[e] != k) begin
            prev = e;
            e = map_links[e];
            steps++;
        end
        if (!(e < ENTRIES && steps < ENTRIES)) e = ENTRIES;
        case (op)
            REQ_INSERT: begin
                if (e != ENTRIES) begin
                    map_vals[e] = v;
                    r.status = ST_OK;
                end else if (map_free >= ENTRIES) begin
                    r.status = ST_NO_MEMORY;
                end else begin
                    n = map_free;
                    map_free = map_links[n];
                    map_keys[n] = k;
                    map_vals[n] = v;
                    map_links[n] = map_heads[b];
                    map_heads[b] = n;
                    map_count++;
                    r.status = ST_OK;
                end
            end
            REQ_LOOKUP: begin
                if (e != ENTRIES) begin
                    r.value_out = map_vals[e];
                    r.status = ST_OK;
                end
            end
            REQ_REMOVE: begin
                if (e != ENTRIES) begin
                    if (prev == ENTRIES) map_heads[b] = map_links[e];
                    else map_links[prev] = map_links[e];
                    map_links[e] = map_free;
                    map_free = e;
                    if (map_count > 0) map_count--;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.entry_count = CNT_W'(map_count);
        return r;
    endfunction

    // Send one request word after a random gap unless no_gap is set; predict at acceptance.
    task automatic send_req(input logic [1:0] op, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v, input bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(7);
        repeat (gap) @(posedge i_clk);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.key      <= k;
        req_ch.value    <= v;
        do @(posedge i_clk); while (!req_ch.ready);
        rsp_expected.push_back(map_apply(op, k, v));
        if (op == REQ_INSERT) known_keys.push_back(k);
        req_ch.valid <= 1'b0;
        // the block stays busy after an accept until its response loads
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (rsp_expected.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Receiver: random ready per word while rx_random is set, plus a long hold-off on request.
    initial begin
        int gap;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold) begin
                rsp_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                rx_hold = 1'b0;
            end else begin
                gap = rx_random ? $urandom_range(7) : 0;
                if (gap != 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // Response checker.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_expected.size() == 0) begin
                $display("%0t: unexpected response word status=%0d", $time, rsp_ch.status);
                errors++;
            end else begin
                t_rsp x;
                x = rsp_expected.pop_front();
                if (rsp_ch.status !== x.status) begin
                    $display("%0t: status exp %0d got %0d", $time, x.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.value_out !== x.value_out) begin
                    $display("%0t: value_out exp %h got %h", $time, x.value_out,
                             rsp_ch.value_out);
                    errors++;
                end
                if (rsp_ch.entry_count !== x.entry_count) begin
                    $display("%0t: entry_count exp %0d got %0d", $time, x.entry_count,
                             rsp_ch.entry_count);
                    errors++;
                end
            end
        end
    end

    // Timeout: worst case is a full pool with long chains; leave plenty of margin.
    always @(posedge i_clk) begin
        if (cycle_count > 3000000) begin
            $display("FAIL chained_hash_map_unit");
            $finish;
        end
    end

    // Extremes of the fields, every op, unknown op, absent remove/lookup, overwrite.
    task automatic test_directed();
        send_req(REQ_LOOKUP, '0, '0);
        send_req(REQ_REMOVE, '1, '0);
        send_req(REQ_INSERT, '0, '1);
        send_req(REQ_INSERT, '1, '0);
        send_req(REQ_LOOKUP, '0, '0);
        send_req(REQ_LOOKUP, '1, '1);
        send_req(REQ_INSERT, '0, 32'h1234_5678);   // overwrite
        send_req(REQ_LOOKUP, '0, '0);
        send_req(2'd3, '0, '1);                     // unknown op: no change
        send_req(2'd3, 64'hAAAA_5555_AAAA_5555, '0);
        send_req(REQ_REMOVE, '0, '0);
        send_req(REQ_LOOKUP, '0, '0);
        send_req(REQ_REMOVE, '0, '0);
        send_req(REQ_INSERT, 64'h5555_AAAA_5555_AAAA, 32'hAAAA_5555);
        send_req(REQ_INSERT, 64'h8000_0000_0000_0001, 32'h5555_AAAA);
        send_req(REQ_LOOKUP, 64'h8000_0000_0000_0001, '0);
        send_req(REQ_REMOVE, '1, '0);
        send_req(REQ_LOOKUP, 64'h5555_AAAA_5555_AAAA, '0);
        wait_drained();
    endtask

    // Keys sharing a bucket: remove from head, middle and tail of one chain.
    task automatic test_collisions();
        logic [KEY_W-1:0] same[$];
        logic [KEY_W-1:0] k;
        int unsigned target;
        target = djb2_bucket(64'h77);
        while (same.size() < 5) begin
            k = {$urandom, $urandom};
            k[7:0] = 8'h00;
            for (int i = 0; i < 256; i++) begin
                k[7:0] = 8'(i);
                if (djb2_bucket(k) == target) begin
                    same.push_back(k);
                    break;
                end
            end
        end
        foreach (same[i]) send_req(REQ_INSERT, same[i], $urandom);
        send_req(REQ_REMOVE, same[2], '0);
        send_req(REQ_REMOVE, same[4], '0);
        send_req(REQ_REMOVE, same[0], '0);
        foreach (same[i]) send_req(REQ_LOOKUP, same[i], '0);
        wait_drained();
    endtask

    // Mixed random traffic, mostly on keys already inserted.
    task automatic test_random(input int count);
        logic [1:0] op;
        logic [KEY_W-1:0] k;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(9) < 5) ? REQ_INSERT :
                 ($urandom_range(9) < 6) ? REQ_LOOKUP :
                 ($urandom_range(19) == 0) ? 2'd3 : REQ_REMOVE;
            if (known_keys.size() != 0 && $urandom_range(3) != 0)
                k = known_keys[$urandom_range(known_keys.size() - 1)];
            else
                k = rand_key();
            send_req(op, k, $urandom);
        end
        wait_drained();
    endtask

    // Receiver holds off while requests keep coming, so the block backs up.
    task automatic test_backpressure();
        rx_hold = 1'b1;
        for (int i = 0; i < 20; i++) send_req(REQ_INSERT, rand_key(), $urandom, 1'b1);
        wait_drained();
    endtask

    // Fill the pool to out of memory, then free a few slots again with removes.
    task automatic test_pool_full();
        logic [KEY_W-1:0] fill_keys[$];
        logic [KEY_W-1:0] k;
        rx_random = 1'b0;
        while (map_count < ENTRIES) begin
            k = rand_key();
            fill_keys.push_back(k);
            send_req(REQ_INSERT, k, $urandom, 1'b1);
        end
        send_req(REQ_INSERT, rand_key(), $urandom);     // out of memory
        send_req(REQ_INSERT, fill_keys[0], '1);        // update still allowed
        send_req(REQ_LOOKUP, fill_keys[0], '0);
        for (int i = 0; i < 40 && i < fill_keys.size(); i++)
            send_req(REQ_REMOVE, fill_keys[i], '0, 1'b1);
        rx_random = 1'b1;
        wait_drained();
    endtask

    initial begin
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.key      = '0;
        req_ch.value    = '0;
        map_clear();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_collisions();
        test_backpressure();
        test_random(120);
        test_random(80);    // sender pauses for a full drain between these
        test_pool_full();
        test_random(30);

        repeat (200) @(posedge i_clk);
        if (errors == 0 && rsp_expected.size() == 0) begin
            $display("PASS chained_hash_map_unit");
        end else begin
            $display("FAIL chained_hash_map_unit");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/chm_pkg.sv
rtl/core/chm_if.sv
rtl/core/chm_ram.sv
rtl/core/chm_hash.sv
rtl/core/chained_hash_map_unit.sv
bench/chained_hash_map_unit_tb.sv
